### sv/rsa_pkg.sv
package rsa_pkg;

    localparam int PRIME_BITS = 16;
    localparam int WORD_BITS  = 32;
    localparam int ACC_BITS   = WORD_BITS + 1;
    localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic [PRIME_BITS-1:0] P_RESET = PRIME_BITS'(61);
    localparam logic [PRIME_BITS-1:0] Q_RESET = PRIME_BITS'(53);

    localparam logic CFG_IDX_P = 1'b0;
    localparam logic CFG_IDX_Q = 1'b1;

    // Job handed from key front end to exponentiation back end
    typedef struct packed {
        logic [WORD_BITS-1:0] message;
        logic [WORD_BITS-1:0] modulus;
        logic [WORD_BITS-1:0] pub_exp;
        logic [WORD_BITS-1:0] priv_exp;
        logic                 fault;
    } rsa_job_t;

endpackage

### sv/rsa_small_key_encrypt_decrypt.sv
// Textbook RSA with small keys.
// Configuration: cfg_we writes prime_p (index 0) or prime_q (index 1) from
// cfg_data. Write only while the block is idle.
// Input channel s_valid/s_ready carries s_message; result channel
// m_valid/m_ready carries cipher, recovered, modulus, both exponents and
// key_fault for every message, one beat out per beat in, in order.
// After reset or any register write, the first message triggers key
// generation (gcd search for e, inverse search for d) on a shared divider.
// Each message with a valid key then costs a reduction and two
// exponentiations on a shared modular multiplier; the back end finishes
// one message before it starts the next.
// A two-entry queue sits between key front end and exponentiation back end,
// so the front can take the next message while a result waits.
// Reset restores p = 61, q = 53 and clears the cached key.
// When m_ready is low the result holds and the back end stalls.
module rsa_small_key_encrypt_decrypt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [rsa_pkg::PRIME_BITS-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_message,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_cipher,
    output logic [31:0]                    m_recovered,
    output logic [31:0]                    m_modulus,
    output logic [31:0]                    m_public_exponent,
    output logic [31:0]                    m_private_exponent,
    output logic                           m_key_fault
);
    import rsa_pkg::*;

    rsa_job_t f_job, q_job;
    logic     f_valid, f_ready, q_valid, q_ready;

    rsa_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index[0]), .cfg_val(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_message(s_message),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rsa_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
    );

    rsa_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cipher(m_cipher), .m_recovered(m_recovered), .m_modulus(m_modulus),
        .m_public_exponent(m_public_exponent),
        .m_private_exponent(m_private_exponent), .m_key_fault(m_key_fault)
    );
endmodule

### sv/rsa_mulmod.sv
// a*b mod m by shift-and-add, one multiplier bit per cycle
module rsa_mulmod (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rsa_pkg::WORD_BITS-1:0]  op_a,
    input  logic [rsa_pkg::WORD_BITS-1:0]  op_b,
    input  logic [rsa_pkg::WORD_BITS-1:0]  op_m,
    output logic                           done,
    output logic [rsa_pkg::WORD_BITS-1:0]  result
);
    import rsa_pkg::*;

    logic [WORD_BITS-1:0] a_reg, b_reg, m_reg, acc_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg, done_reg;
    logic [ACC_BITS-1:0]  dbl, dsum;
    logic [WORD_BITS-1:0] acc_next;

    // acc = 2*acc + bit*a, MSB first, each add reduced once
    always_comb begin
        dbl = {acc_reg, 1'b0};
        if (dbl >= {1'b0, m_reg}) dbl = dbl - {1'b0, m_reg};
        dsum = dbl + {1'b0, a_reg};
        if (b_reg[WORD_BITS-1] && dsum >= {1'b0, m_reg}) dsum = dsum - {1'b0, m_reg};
        acc_next = b_reg[WORD_BITS-1] ? dsum[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= op_a;
                b_reg    <= op_b;
                m_reg    <= op_m;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule

### sv/rsa_front.sv
// Key generation and message intake: derives n, e, d once per config change
module rsa_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_idx,
    input  logic [rsa_pkg::PRIME_BITS-1:0]  cfg_val,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rsa_pkg::WORD_BITS-1:0]   s_message,
    output logic                            job_valid,
    input  logic                            job_ready,
    output rsa_pkg::rsa_job_t               job
);
    import rsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_GCD_INIT, ST_GCD, ST_GCD_DONE,
        ST_INV_INIT, ST_INV, ST_MUL, ST_SEND
    } fstate_t;

    fstate_t state_reg;
    logic [PRIME_BITS-1:0] p_reg, q_reg;
    logic                  key_ready_reg;
    logic [WORD_BITS-1:0]  n_reg, phi_reg, e_reg, d_reg, msg_reg;
    logic [WORD_BITS-1:0]  ga_reg, gb_reg;
    logic [WORD_BITS-1:0]  step_reg, res_reg, k_reg, quo_reg;
    logic [WORD_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]   bit_reg;
    logic                  key_fault_reg;
    logic [WORD_BITS-1:0]  div_n_reg, div_d_reg;
    logic                  div_busy_reg;
    logic [2:0]            div_use_reg;
    logic [ACC_BITS-1:0]   rsum;
    logic [WORD_BITS:0]    rtry;

    localparam logic [2:0] DU_GCD = 3'd0;
    localparam logic [2:0] DU_STEP = 3'd1;
    localparam logic [2:0] DU_QUO = 3'd2;
    localparam logic [2:0] DU_KDIV = 3'd3;

    // restoring divider step: one quotient bit a cycle
    assign rtry = {rem_reg, div_n_reg[WORD_BITS-1]} - {1'b0, div_d_reg};
    // residue update for the inverse search
    assign rsum = {1'b0, res_reg} + {1'b0, step_reg};

    assign s_ready   = (state_reg == ST_IDLE);
    assign job_valid = (state_reg == ST_SEND);
    always_comb begin
        job.message  = msg_reg;
        job.modulus  = key_fault_reg ? '0 : n_reg;
        job.pub_exp  = key_fault_reg ? '0 : e_reg;
        job.priv_exp = key_fault_reg ? '0 : d_reg;
        job.fault    = key_fault_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            p_reg         <= P_RESET;
            q_reg         <= Q_RESET;
            key_ready_reg <= 1'b0;
            key_fault_reg <= 1'b1;
            div_busy_reg  <= 1'b0;
            bit_reg       <= '0;
            div_use_reg   <= DU_KDIV;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_IDX_P) p_reg <= cfg_val;
                else                      q_reg <= cfg_val;
                key_ready_reg <= 1'b0;
            end
            // shared divider
            if (div_busy_reg) begin
                if (!rtry[WORD_BITS]) rem_reg <= rtry[WORD_BITS-1:0];
                else rem_reg <= {rem_reg[WORD_BITS-2:0], div_n_reg[WORD_BITS-1]};
                div_n_reg <= {div_n_reg[WORD_BITS-2:0], ~rtry[WORD_BITS]};
                bit_reg   <= bit_reg + 1'b1;
                if (bit_reg == CNT_BITS'(WORD_BITS - 1)) div_busy_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        msg_reg <= s_message;
                        state_reg <= key_ready_reg ? ST_SEND : ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    n_reg <= WORD_BITS'(p_reg) * WORD_BITS'(q_reg);
                    phi_reg <= WORD_BITS'(p_reg - 1'b1) * WORD_BITS'(q_reg - 1'b1);
                    e_reg <= WORD_BITS'(2);
                    key_ready_reg <= 1'b1;
                    key_fault_reg <= 1'b0;
                    if (p_reg < PRIME_BITS'(2) || q_reg < PRIME_BITS'(2)) begin
                        key_fault_reg <= 1'b1;
                        state_reg <= ST_SEND;
                    end else begin
                        state_reg <= ST_GCD_INIT;
                    end
                end
                ST_GCD_INIT: begin
                    ga_reg <= e_reg;
                    gb_reg <= phi_reg;
                    state_reg <= ST_GCD;
                end
                ST_GCD: begin
                    // Euclid: each remainder from the shared divider
                    if (!div_busy_reg) begin
                        if (div_use_reg == DU_GCD && bit_reg == CNT_BITS'(WORD_BITS)) begin
                            ga_reg <= gb_reg;
                            gb_reg <= rem_reg;
                            bit_reg <= '0;
                        end else if (gb_reg == '0) begin
                            state_reg <= ST_GCD_DONE;
                        end else begin
                            div_n_reg <= ga_reg;
                            div_d_reg <= gb_reg;
                            rem_reg <= '0;
                            bit_reg <= '0;
                            div_use_reg <= DU_GCD;
                            div_busy_reg <= 1'b1;
                        end
                    end
                end
                ST_GCD_DONE: begin
                    bit_reg <= '0;
                    div_use_reg <= DU_KDIV;
                    if (ga_reg == WORD_BITS'(1)) begin
                        state_reg <= ST_INV_INIT;
                    end else if (e_reg < phi_reg) begin
                        e_reg <= e_reg + 1'b1;
                        state_reg <= ST_GCD_INIT;
                    end else begin
                        key_fault_reg <= 1'b1;
                        state_reg <= ST_SEND;
                    end
                end
                ST_INV_INIT: begin
                    // phi / e: quotient and remainder (step)
                    if (!div_busy_reg) begin
                        if (div_use_reg == DU_STEP && bit_reg == CNT_BITS'(WORD_BITS)) begin
                            step_reg <= rem_reg;
                            quo_reg  <= div_n_reg;
                            res_reg  <= (e_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                            k_reg    <= '0;
                            state_reg <= ST_INV;
                        end else begin
                            div_n_reg <= phi_reg;
                            div_d_reg <= e_reg;
                            rem_reg <= '0;
                            bit_reg <= '0;
                            div_use_reg <= DU_STEP;
                            div_busy_reg <= 1'b1;
                        end
                    end
                end
                ST_INV: begin
                    // walk k until 1 + k*phi is a multiple of e
                    if (res_reg == '0) begin
                        state_reg <= ST_MUL;
                        div_use_reg <= DU_QUO;
                        bit_reg <= '0;
                    end else if (k_reg >= e_reg) begin
                        key_fault_reg <= 1'b1;
                        state_reg <= ST_SEND;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        res_reg <= (rsum >= {1'b0, e_reg}) ?
                            WORD_BITS'(rsum - {1'b0, e_reg}) : rsum[WORD_BITS-1:0];
                    end
                end
                ST_MUL: begin
                    // d = k*(phi/e) + (1 + k*step)/e
                    if (!div_busy_reg) begin
                        if (div_use_reg == DU_KDIV && bit_reg == CNT_BITS'(WORD_BITS)) begin
                            d_reg <= d_reg + div_n_reg;
                            state_reg <= ST_SEND;
                        end else begin
                            d_reg <= WORD_BITS'(k_reg * quo_reg);
                            div_n_reg <= WORD_BITS'(WORD_BITS'(1) + k_reg * step_reg);
                            div_d_reg <= e_reg;
                            rem_reg <= '0;
                            bit_reg <= '0;
                            div_use_reg <= DU_KDIV;
                            div_busy_reg <= 1'b1;
                        end
                    end
                end
                ST_SEND: begin
                    if (job_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### sv/rsa_queue.sv
// Short job queue between front and back ends
module rsa_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsa_pkg::rsa_job_t  in_job,
    output logic               out_valid,
    input  logic               out_ready,
    output rsa_pkg::rsa_job_t  out_job
);
    import rsa_pkg::*;

    rsa_job_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [QPTR_BITS:0]   cnt_reg;
    logic                 push, pop;

    assign in_ready  = (cnt_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_job = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                mem_reg[wp_reg] <= in_job;
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) rp_reg <= rp_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end
endmodule

### sv/rsa_back.sv
// Two square-and-multiply exponentiations on one shared modular multiplier
module rsa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  rsa_pkg::rsa_job_t              job,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rsa_pkg::WORD_BITS-1:0]  m_cipher,
    output logic [rsa_pkg::WORD_BITS-1:0]  m_recovered,
    output logic [rsa_pkg::WORD_BITS-1:0]  m_modulus,
    output logic [rsa_pkg::WORD_BITS-1:0]  m_public_exponent,
    output logic [rsa_pkg::WORD_BITS-1:0]  m_private_exponent,
    output logic                           m_key_fault
);
    import rsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_LOOP, ST_MULR, ST_WAITR, ST_SQR, ST_WAITS,
        ST_PHASE, ST_OUT
    } bstate_t;

    bstate_t state_reg;
    rsa_job_t job_reg;
    logic [WORD_BITS-1:0] base_reg, r_reg, ex_reg, c_reg;
    logic                 second_reg;
    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_a, mm_b;
    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_res;
    logic                 m_valid_reg;

    // base mod n is 1*base mod n; the multiplicand must stay below n
    assign mm_a = (state_reg == ST_RED)  ? WORD_BITS'(1) :
                  (state_reg == ST_MULR) ? r_reg : base_reg;
    assign mm_b = base_reg;
    assign mm_start = (state_reg == ST_RED) || (state_reg == ST_MULR) ||
                      (state_reg == ST_SQR);

    rsa_mulmod u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start),
        .op_a(mm_a), .op_b(mm_b), .op_m(job_reg.modulus),
        .done(mm_done), .result(mm_res)
    );

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_cipher = job_reg.fault ? '0 : c_reg;
    assign m_recovered = job_reg.fault ? '0 : r_reg;
    assign m_modulus = job_reg.modulus;
    assign m_public_exponent = job_reg.pub_exp;
    assign m_private_exponent = job_reg.priv_exp;
    assign m_key_fault = job_reg.fault;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg <= job;
                        base_reg <= job.message;
                        ex_reg <= job.pub_exp;
                        second_reg <= 1'b0;
                        state_reg <= job.fault ? ST_OUT : ST_RED;
                    end
                end
                ST_RED: state_reg <= ST_WAITS;
                ST_LOOP: begin
                    if (ex_reg == '0) state_reg <= ST_PHASE;
                    else if (ex_reg[0]) state_reg <= ST_MULR;
                    else state_reg <= ST_SQR;
                end
                ST_MULR: state_reg <= ST_WAITR;
                ST_WAITR: begin
                    if (mm_done) begin
                        r_reg <= mm_res;
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: state_reg <= ST_WAITS;
                ST_WAITS: begin
                    if (mm_done) begin
                        base_reg <= mm_res;
                        state_reg <= ST_LOOP;
                    end
                end
                ST_PHASE: begin
                    if (!second_reg) begin
                        c_reg <= r_reg;
                        base_reg <= r_reg;
                        ex_reg <= job_reg.priv_exp;
                        second_reg <= 1'b1;
                        r_reg <= (job_reg.modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                        state_reg <= ST_LOOP;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg) m_valid_reg <= 1'b1;
                    else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // reduction start: r = 1 mod n, exponent shifts as each square starts
            if (state_reg == ST_IDLE && job_valid)
                r_reg <= (job.modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            if (state_reg == ST_SQR) ex_reg <= ex_reg >> 1;
        end
    end
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rsa_pkg::*;

    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [31:0] cipher;
        logic [31:0] recovered;
        logic [31:0] modulus;
        logic [31:0] pub_exp;
        logic [31:0] priv_exp;
        logic        fault;
    } rsa_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [PRIME_BITS-1:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_message;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_cipher;
    logic [31:0] m_recovered;
    logic [31:0] m_modulus;
    logic [31:0] m_public_exponent;
    logic [31:0] m_private_exponent;
    logic        m_key_fault;

    rsa_small_key_encrypt_decrypt u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_message          (s_message),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_cipher           (m_cipher),
        .m_recovered        (m_recovered),
        .m_modulus          (m_modulus),
        .m_public_exponent  (m_public_exponent),
        .m_private_exponent (m_private_exponent),
        .m_key_fault        (m_key_fault)
    );

    // Predictor state
    longint unsigned pred_p, pred_q;
    longint unsigned key_n, key_e, key_d;
    bit              key_valid;
    rsa_result_t     expected_results[$];
    int              fail_count;
    int              hold_off_cycles;
    bit              quiet_mode;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint unsigned modexp(longint unsigned b, longint unsigned x,
                                               longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        b = b % m;
        while (x != 0) begin
            if (x[0])
                r = (r * b) % m;
            b = (b * b) % m;
            x = x >> 1;
        end
        return r;
    endfunction

    // Key derivation: smallest coprime e, then inverse via smallest k
    task automatic derive_key();
        longint unsigned phi, e, k, stp, res;
        key_n = 0;
        key_e = 0;
        key_d = 0;
        key_valid = 1'b1;
        if (pred_p < 2 || pred_q < 2)
            return;
        phi = (pred_p - 1) * (pred_q - 1);
        e = 2;
        while (e < phi && gcd64(e, phi) != 1)
            e++;
        if (gcd64(e, phi) != 1)
            return;
        stp = phi % e;
        res = 1 % e;
        k = 0;
        while (res != 0 && k < e) begin
            k++;
            res = (res + stp) % e;
        end
        if (res != 0)
            return;
        key_n = pred_p * pred_q;
        key_e = e;
        key_d = k * (phi / e) + (1 + k * stp) / e;
    endtask

    function automatic rsa_result_t encrypt_decrypt(logic [31:0] msg);
        rsa_result_t r;
        longint unsigned c;
        longint unsigned pt;
        r = '{default: '0};
        if (key_e == 0) begin
            r.fault = 1'b1;
            return r;
        end
        c = modexp(msg, key_e, key_n);
        pt = modexp(c, key_d, key_n);
        r.cipher    = c[31:0];
        r.recovered = pt[31:0];
        r.modulus   = key_n[31:0];
        r.pub_exp   = key_e[31:0];
        r.priv_exp  = key_d[31:0];
        return r;
    endfunction

    // Send one message beat; valid stays up across back-to-back beats
    task automatic send_message(logic [31:0] msg, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_message <= msg;
        do @(posedge aclk); while (!s_ready);
        if (!key_valid)
            derive_key();
        expected_results.push_back(encrypt_decrypt(msg));
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Reprogram both factors once every result is back
    task automatic set_primes(logic [PRIME_BITS-1:0] p, logic [PRIME_BITS-1:0] q);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_P;
        cfg_data  <= p;
        @(posedge aclk);
        cfg_index <= CFG_IDX_Q;
        cfg_data  <= q;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pred_p = p;
        pred_q = q;
        key_valid = 1'b0;
    endtask

    function automatic logic [31:0] edge_message();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return key_n[31:0];
            3: return key_n[31:0] - 32'd1;
            4: return 32'h1;
            default: return $urandom();
        endcase
    endfunction

    // Reset key (61, 53) with extreme messages
    task automatic test_default_key();
        send_message(32'h0, 0);
        send_message(32'hFFFF_FFFF, 0);
        send_message(32'd65, 1);
        send_message(32'd3233, 0);
        send_message(32'd3232, 2);
        send_message(32'h8000_0001, 0);
    endtask

    // Degenerate and extreme factor pairs
    task automatic test_special_factors();
        logic [PRIME_BITS-1:0] pairs[10][2];
        pairs = '{'{16'hFFFF, 16'hFFFF}, '{16'd2, 16'd2}, '{16'd2, 16'd3},
                  '{16'd3, 16'd2}, '{16'd0, 16'd7}, '{16'd7, 16'd1},
                  '{16'd1, 16'd1}, '{16'hFFFF, 16'd2}, '{16'hFFF1, 16'hFFEF},
                  '{16'd0, 16'd0}};
        foreach (pairs[i]) begin
            set_primes(pairs[i][0], pairs[i][1]);
            send_message(32'hFFFF_FFFF, 0);
            send_message(32'h0, 0);
        end
    endtask

    // Random factors, random messages
    task automatic test_random_keys();
        logic [PRIME_BITS-1:0] p, q;
        for (int ph = 0; ph < 10; ph++) begin
            p = ($urandom_range(0, 2) == 0) ? PRIME_BITS'($urandom_range(2, 400)) :
                                              PRIME_BITS'($urandom());
            q = ($urandom_range(0, 2) == 0) ? PRIME_BITS'($urandom_range(2, 400)) :
                                              PRIME_BITS'($urandom());
            set_primes(p, q);
            quiet_mode = (ph % 4 == 3);
            for (int i = 0; i < 55; i++)
                send_message(($urandom_range(0, 9) == 0) ? edge_message() : $urandom(),
                             pick_gap());
            quiet_mode = 1'b0;
        end
    endtask

    // Receiver holds off long enough to fill the internal queue
    task automatic test_backpressure();
        set_primes(16'd61, 16'd53);
        hold_off_cycles = 15000;
        for (int i = 0; i < 8; i++)
            send_message($urandom(), 0);
    endtask

    // Result checker and receiver stalls
    initial begin : result_checker
        rsa_result_t exp_r;
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_cipher !== exp_r.cipher) begin
                        $error("cipher: expected %0d actual %0d", exp_r.cipher, m_cipher);
                        fail_count++;
                    end
                    if (m_recovered !== exp_r.recovered) begin
                        $error("recovered: expected %0d actual %0d",
                               exp_r.recovered, m_recovered);
                        fail_count++;
                    end
                    if (m_modulus !== exp_r.modulus) begin
                        $error("modulus: expected %0d actual %0d", exp_r.modulus, m_modulus);
                        fail_count++;
                    end
                    if (m_public_exponent !== exp_r.pub_exp) begin
                        $error("public_exponent: expected %0d actual %0d",
                               exp_r.pub_exp, m_public_exponent);
                        fail_count++;
                    end
                    if (m_private_exponent !== exp_r.priv_exp) begin
                        $error("private_exponent: expected %0d actual %0d",
                               exp_r.priv_exp, m_private_exponent);
                        fail_count++;
                    end
                    if (m_key_fault !== exp_r.fault) begin
                        $error("key_fault: expected %0d actual %0d", exp_r.fault, m_key_fault);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (quiet_mode) begin
                m_ready <= 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2: stall_left = $urandom_range(1, 4);
                    3:       stall_left = $urandom_range(30, 300);
                    default: stall_left = 0;
                endcase
                m_ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("rsa_small_key_encrypt_decrypt verification failed");
                $finish;
            end
        end
    end

    initial begin : main_sequence
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IDX_P;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_message = '0;
        fail_count = 0;
        hold_off_cycles = 0;
        quiet_mode = 1'b0;
        pred_p = 61;
        pred_q = 53;
        key_valid = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_key();
        test_special_factors();
        test_backpressure();
        test_random_keys();

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("rsa_small_key_encrypt_decrypt verification clean");
        else
            $display("rsa_small_key_encrypt_decrypt verification failed");
        $finish;
    end

endmodule
